// ===== src/event_circle_timestamp_sort_unit_assert.svh =====
// Assertion macros for the circle timestamp sort unit.
// Used by the cell chain and the top level; no dependencies.
`ifndef EVENT_CIRCLE_TIMESTAMP_SORT_UNIT_ASSERT_SVH
`define EVENT_CIRCLE_TIMESTAMP_SORT_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define ECS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ECS_ASSERT_NEXT(lbl, clk, rstn, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) else $error(msg);
`else
`define ECS_ASSERT(lbl, clk, rstn, prop, msg)
`define ECS_ASSERT_NEXT(lbl, clk, rstn, a, b, msg)
`endif
`endif

// ===== src/ecs_pkg.sv =====
// Shared constants, offset tables and types for the circle timestamp sort unit.
// No dependencies.
package ecs_pkg;
  localparam int FrameWidth  = 240;
  localparam int FrameHeight = 180;
  localparam int TsBits      = 16;
  localparam int Depth       = FrameWidth * FrameHeight;
  localparam int AddrBits    = $clog2(Depth);
  localparam int InnerCount  = 16;
  localparam int OuterCount  = 20;
  localparam int NumCells    = OuterCount;
  localparam int IdxBits     = $clog2(OuterCount + 1);
  localparam int CoordBits   = 13;

  localparam logic [1:0] ReqInner = 2'd0;
  localparam logic [1:0] ReqOuter = 2'd1;

  typedef logic [TsBits-1:0] ts_t;

  typedef struct packed {
    logic clear;
    logic ins;
    ts_t  val;
  } cell_ctl_t;

  function automatic logic [7:0] circle_offset(input logic outer, input logic [4:0] idx);
    logic [7:0] r;
    r = 8'h00;
    if (!outer) begin
      case (idx[3:0])
        4'd0: r = 8'hf3;  4'd1: r = 8'he2;  4'd2: r = 8'hd1;  4'd3: r = 8'hd0;
        4'd4: r = 8'hdf;  4'd5: r = 8'hee;  4'd6: r = 8'hfd;  4'd7: r = 8'h0d;
        4'd8: r = 8'h1d;  4'd9: r = 8'h2e;  4'd10: r = 8'h3f; 4'd11: r = 8'h30;
        4'd12: r = 8'h31; 4'd13: r = 8'h22; 4'd14: r = 8'h13; default: r = 8'h03;
      endcase
    end else begin
      case (idx)
        5'd0: r = 8'hf4;  5'd1: r = 8'he3;  5'd2: r = 8'hd2;  5'd3: r = 8'hc1;
        5'd4: r = 8'hc0;  5'd5: r = 8'hcf;  5'd6: r = 8'hde;  5'd7: r = 8'hed;
        5'd8: r = 8'hfc;  5'd9: r = 8'h0c;  5'd10: r = 8'h1c; 5'd11: r = 8'h2d;
        5'd12: r = 8'h3e; 5'd13: r = 8'h4f; 5'd14: r = 8'h40; 5'd15: r = 8'h41;
        5'd16: r = 8'h32; 5'd17: r = 8'h23; 5'd18: r = 8'h14; 5'd19: r = 8'h04;
        default: r = 8'h00;
      endcase
    end
    return r;
  endfunction
endpackage

// ===== src/ecs_sort_cell.sv =====
// One cell of the insertion sort chain: holds a value and a fill flag.
// Depends on ecs_pkg.
module ecs_sort_cell import ecs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_ctl_t ctl_i,
  input  logic      prev_full_i,
  input  logic      prev_gt_i,
  input  ts_t       prev_val_i,
  output logic      full_o,
  output logic      gt_o,
  output ts_t       val_o
);
  logic full_q, full_d;
  ts_t  val_q, val_d;

  assign gt_o = full_q && (val_q > ctl_i.val);

  always_comb begin
    full_d = full_q;
    val_d  = val_q;
    if (ctl_i.clear) begin
      full_d = 1'b0;
    end else if (ctl_i.ins && (gt_o || (!full_q && prev_full_i))) begin
      full_d = 1'b1;
      val_d  = prev_gt_i ? prev_val_i : ctl_i.val;
    end
  end

  // first cell that is empty or larger takes the new beat, those behind shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) full_q <= 1'b0;
    else         full_q <= full_d;
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign full_o = full_q;
  assign val_o  = val_q;
endmodule

// ===== src/ecs_sort_chain.sv =====
// Chain of sort cells; keeps inserted values ascending, drains from the head.
// Depends on ecs_pkg, ecs_sort_cell and the assertion header.
`include "event_circle_timestamp_sort_unit_assert.svh"
module ecs_sort_chain import ecs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic clear_i,
  input  logic ins_i,
  input  ts_t  ins_val_i,
  input  logic [IdxBits-1:0] rd_idx_i,
  output ts_t  rd_val_o
);
  logic [NumCells-1:0] full, gt;
  ts_t  vals [NumCells];
  cell_ctl_t ctl;

  assign ctl = '{clear: clear_i, ins: ins_i, val: ins_val_i};

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    logic pf, pg;
    ts_t  pv;
    if (g == 0) begin : g_head
      assign pf = 1'b1;
      assign pg = 1'b0;
      assign pv = '0;
    end else begin : g_body
      assign pf = full[g-1];
      assign pg = gt[g-1];
      assign pv = vals[g-1];
    end
    ecs_sort_cell u_cell (
      .clk_i(clk_i), .rst_ni(rst_ni), .ctl_i(ctl),
      .prev_full_i(pf), .prev_gt_i(pg), .prev_val_i(pv),
      .full_o(full[g]), .gt_o(gt[g]), .val_o(vals[g])
    );
  end

  assign rd_val_o = vals[rd_idx_i[$clog2(NumCells)-1:0]];

  `ECS_ASSERT_NEXT(a_clear_empties, clk_i, rst_ni, clear_i, full == '0, "chain not cleared")
  `ECS_ASSERT(a_no_ins_full, clk_i, rst_ni, !(ins_i && full[NumCells-1]), "chain overflow")
  `ECS_ASSERT(a_fill_prefix, clk_i, rst_ni, ((full + 1'b1) & full) == '0, "fill not a prefix")
endmodule

// ===== src/event_circle_timestamp_sort_unit.sv =====
// Top level: time surface memory, circle address sequencer and sort drain.
// Depends on ecs_pkg, ecs_sort_chain and the assertion header.
// A start walks the read states over the circle (request 0 inner, request 1 outer),
// then the pipeline tail and the drain; a new event is taken only back in idle.
// Reset clears control at once, then a clearing pass zeroes the surface with busy
// held high. The receiver cannot stall: results go out one per cycle.
`include "event_circle_timestamp_sort_unit_assert.svh"
module event_circle_timestamp_sort_unit import ecs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  pixel_x_i,
  input  logic [7:0]  pixel_y_i,
  input  logic [15:0] event_time_i,
  output logic        result_valid_o,
  output logic [15:0] sorted_time_o,
  output logic        last_of_run_o
);
  localparam logic [2:0] StClr  = 3'd0;
  localparam logic [2:0] StIdle = 3'd1;
  localparam logic [2:0] StRead = 3'd2;
  localparam logic [2:0] StTail = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  logic [2:0] st_q, st_d;
  logic [AddrBits-1:0] clr_q, clr_d;
  logic outer_q, outer_d;
  logic [7:0] px_q, px_d, py_q, py_d;
  logic [IdxBits-1:0] idx_q, idx_d, cnt_q, cnt_d;
  logic [1:0] tail_q, tail_d;
  logic rv1_q, ok1_q;

  ts_t mem [Depth];
  ts_t rd_q;

  logic we;
  logic [AddrBits-1:0] waddr, raddr;
  ts_t wdata;
  logic re, rok;
  logic signed [CoordBits-1:0] nx, ny;
  logic [7:0] off;
  logic accept;
  logic chain_clear, chain_ins;
  ts_t chain_val, chain_rd;
  logic [IdxBits-1:0] count;

  assign accept = start && !busy;
  assign busy = (st_q != StIdle);
  assign count = outer_q ? IdxBits'(OuterCount) : IdxBits'(InnerCount);
  assign off = circle_offset(outer_q, idx_q[4:0]);
  assign nx = $signed({5'd0, px_q}) + CoordBits'($signed(off[3:0]));
  assign ny = $signed({5'd0, py_q}) + CoordBits'($signed(off[7:4]));
  assign rok = (nx >= 0) && (nx < FrameWidth) && (ny >= 0) && (ny < FrameHeight);
  assign re = (st_q == StRead);
  assign raddr = AddrBits'($unsigned(ny)) * AddrBits'(FrameWidth) + AddrBits'($unsigned(nx));

  always_comb begin
    we = 1'b0;
    waddr = clr_q;
    wdata = '0;
    if (st_q == StClr) begin
      we = 1'b1;
    end else if (accept && req_type_i == ReqInner && pixel_x_i < FrameWidth &&
                 pixel_y_i < FrameHeight) begin
      we = 1'b1;
      waddr = AddrBits'(pixel_y_i) * AddrBits'(FrameWidth) + AddrBits'(pixel_x_i);
      wdata = event_time_i[TsBits-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rd_q <= mem[raddr];
  end

  always_comb begin
    st_d = st_q; clr_d = clr_q; outer_d = outer_q; px_d = px_q; py_d = py_q;
    idx_d = idx_q; cnt_d = cnt_q; tail_d = tail_q;
    chain_clear = 1'b0;
    unique case (st_q)
      StClr: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == AddrBits'(Depth - 1)) st_d = StIdle;
      end
      StIdle: begin
        if (accept && (req_type_i == ReqInner || req_type_i == ReqOuter)) begin
          st_d = StRead; outer_d = (req_type_i == ReqOuter);
          px_d = pixel_x_i; py_d = pixel_y_i; idx_d = '0; chain_clear = 1'b1;
        end
      end
      StRead: begin
        idx_d = idx_q + 1'b1;
        if (idx_q == count - 1'b1) begin st_d = StTail; tail_d = '0; end
      end
      StTail: begin
        tail_d = tail_q + 1'b1;
        if (tail_q == 2'd2) begin st_d = StOut; cnt_d = '0; end
      end
      StOut: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == count - 1'b1) st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClr; clr_q <= '0; idx_q <= '0; cnt_q <= '0; tail_q <= '0;
      rv1_q <= 1'b0; outer_q <= 1'b0;
    end else begin
      st_q <= st_d; clr_q <= clr_d; idx_q <= idx_d; cnt_q <= cnt_d; tail_q <= tail_d;
      rv1_q <= re; outer_q <= outer_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q <= px_d; py_q <= py_d; ok1_q <= rok;
  end

  assign chain_ins = rv1_q;
  assign chain_val = ok1_q ? rd_q : '0;

  ecs_sort_chain u_chain (
    .clk_i(clk_i), .rst_ni(rst_ni), .clear_i(chain_clear), .ins_i(chain_ins),
    .ins_val_i(chain_val), .rd_idx_i(cnt_q), .rd_val_o(chain_rd)
  );

  assign result_valid_o = (st_q == StOut);
  assign sorted_time_o  = 16'(chain_rd);
  assign last_of_run_o  = (st_q == StOut) && (cnt_q == count - 1'b1);

  `ECS_ASSERT(a_no_write_busy, clk_i, rst_ni, !(we && st_q != StClr && busy), "write while busy")
  `ECS_ASSERT(a_last_valid, clk_i, rst_ni, !last_of_run_o || result_valid_o, "stray last")
  `ECS_ASSERT_NEXT(a_last_idle, clk_i, rst_ni, last_of_run_o, st_q == StIdle, "no idle after last")
endmodule
